### design/look_at_view_matrix_core_defines.svh
// ============================================================================
// look_at_view_matrix_core_defines
// Assertion macros shared by the look-at view matrix checker.
// ============================================================================
`ifndef LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH

// Check that is off while reset is held.
`define LAVM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also covers the reset cycles.
`define LAVM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/lavm_pkg.sv
// ============================================================================
// lavm_pkg
// Widths, types and row codes for the look-at view matrix core.
// ============================================================================
package lavm_pkg;

    localparam int EYE_W      = 32;           // Q16.16 coordinate
    localparam int FRAC_W     = 16;
    localparam int VEC_W      = 36;           // signed vector into a normalizer
    localparam int MAG_W      = VEC_W - 1;
    localparam int POS_W      = 6;            // bit position in a magnitude
    localparam int NRM_W      = 30;           // scaled magnitude, top in [2^29, 2^30)
    localparam int NRM_TOP    = NRM_W - 1;
    localparam int SQR_W      = 2 * NRM_W;
    localparam int SQ_W       = 62;           // sum of three squares
    localparam int LEN_W      = 31;           // vector length
    localparam int SQRT_STEPS = LEN_W;
    localparam int QUO_W      = FRAC_W + 1;   // unit component magnitude
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_W      = 48;
    localparam int UNIT_W     = QUO_W + 1;    // signed unit component
    localparam int PRD_W      = UNIT_W + EYE_W;
    localparam int DOT_W      = PRD_W + 2;
    localparam int ROW_W      = 2;

    typedef enum logic [ROW_W-1:0] {
        ROW_RIGHT = 2'd0,
        ROW_UP    = 2'd1,
        ROW_DIR   = 2'd2
    } row_t;

    typedef logic [2:0][UNIT_W-1:0] unit_vec_t;
    typedef logic [2:0][EYE_W-1:0]  eye_vec_t;
    typedef logic [2:0][VEC_W-1:0]  wide_vec_t;

    typedef struct packed {
        logic valid;
        logic ok;
    } nrm_stat_t;

endpackage

### design/lavm_norm.sv
// ============================================================================
// lavm_norm
// Pipelined 3-vector normalizer: scale, sum of squares, digit-per-stage
// square root, restoring divide per component, sign restore.
// ============================================================================
module lavm_norm #(
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  lavm_pkg::wide_vec_t   in_vec,
    input  logic [SIDE_W-1:0]     in_side,
    output lavm_pkg::nrm_stat_t   out_stat,
    output lavm_pkg::unit_vec_t   out_vec,
    output logic [SIDE_W-1:0]     out_side
);
    import lavm_pkg::*;

    typedef struct packed {
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } tag_t;

    typedef logic [2:0][MAG_W-1:0] mag_vec_t;
    typedef logic [2:0][NRM_W-1:0] nrm_vec_t;
    typedef logic [2:0][DIV_W-1:0] rem_vec_t;
    typedef logic [2:0][QUO_W-1:0] quo_vec_t;

    // stage 1: magnitudes and maximum
    logic             v1_reg;
    tag_t             t1_reg;
    mag_vec_t         mag1_reg, mag1_next;
    logic [MAG_W-1:0] max1_reg, max1_next;
    logic [2:0]       neg1_next;

    always_comb begin
        max1_next = '0;
        for (int i = 0; i < 3; i++) begin
            neg1_next[i] = in_vec[i][VEC_W-1];
            mag1_next[i] = neg1_next[i] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
            if (mag1_next[i] > max1_next) begin
                max1_next = mag1_next[i];
            end
        end
    end

    // stage 2: leading one position
    logic             v2_reg;
    tag_t             t2_reg;
    mag_vec_t         mag2_reg;
    logic [POS_W-1:0] pos2_reg, pos2_next;

    always_comb begin
        pos2_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (max1_reg[i]) begin
                pos2_next = POS_W'(i);
            end
        end
    end

    // stage 3: scale into [2^29, 2^30)
    logic             v3_reg;
    tag_t             t3_reg;
    nrm_vec_t         nrm3_reg, nrm3_next;
    logic             down3;
    logic [POS_W-1:0] sh3;

    always_comb begin
        down3 = (pos2_reg >= POS_W'(NRM_TOP));
        sh3   = down3 ? (pos2_reg - POS_W'(NRM_TOP)) : (POS_W'(NRM_TOP) - pos2_reg);
        for (int i = 0; i < 3; i++) begin
            nrm3_next[i] = down3 ? NRM_W'(mag2_reg[i] >> sh3) : NRM_W'(mag2_reg[i] << sh3);
        end
    end

    // stage 4: squares
    logic                       v4_reg;
    tag_t                       t4_reg;
    nrm_vec_t                   nrm4_reg;
    logic [2:0][SQR_W-1:0]      sq4_reg, sq4_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq4_next[i] = SQR_W'(nrm3_reg[i]) * SQR_W'(nrm3_reg[i]);
        end
    end

    // stage 5 and square root chain; entry 0 holds the sum of squares
    logic            sv_reg  [SQRT_STEPS+1];
    tag_t            st_reg  [SQRT_STEPS+1];
    nrm_vec_t        snm_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0] sqx_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0] sqr_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0] sqx_next[SQRT_STEPS+1];
    logic [SQ_W-1:0] sqr_next[SQRT_STEPS+1];
    logic [SQ_W-1:0] sq_bit, sq_trial;

    always_comb begin
        sqx_next[0] = SQ_W'(sq4_reg[0]) + SQ_W'(sq4_reg[1]) + SQ_W'(sq4_reg[2]);
        sqr_next[0] = '0;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            sq_bit   = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
            sq_trial = sqr_reg[j] + sq_bit;
            if (sqx_reg[j] >= sq_trial) begin
                sqx_next[j+1] = sqx_reg[j] - sq_trial;
                sqr_next[j+1] = (sqr_reg[j] >> 1) + sq_bit;
            end else begin
                sqx_next[j+1] = sqx_reg[j];
                sqr_next[j+1] = sqr_reg[j] >> 1;
            end
        end
    end

    // divide chain; entry 0 holds the rounded dividend
    logic             dv_reg [DIV_STEPS+1];
    tag_t             dt_reg [DIV_STEPS+1];
    logic [LEN_W-1:0] dl_reg [DIV_STEPS+1];
    rem_vec_t         dr_reg [DIV_STEPS+1];
    quo_vec_t         dq_reg [DIV_STEPS+1];
    rem_vec_t         dr_next[DIV_STEPS+1];
    quo_vec_t         dq_next[DIV_STEPS+1];
    logic [LEN_W-1:0] len_next;
    logic [DIV_W-1:0] d_shift;

    always_comb begin
        len_next = sqr_reg[SQRT_STEPS][LEN_W-1:0];
        for (int i = 0; i < 3; i++) begin
            dr_next[0][i] = DIV_W'({snm_reg[SQRT_STEPS][i], FRAC_W'(0)})
                          + DIV_W'(len_next >> 1);
            dq_next[0][i] = '0;
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            d_shift = DIV_W'(dl_reg[j]) << (DIV_STEPS - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (dr_reg[j][i] >= d_shift) begin
                    dr_next[j+1][i] = dr_reg[j][i] - d_shift;
                    dq_next[j+1][i] = dq_reg[j][i] | (QUO_W'(1) << (DIV_STEPS - 1 - j));
                end else begin
                    dr_next[j+1][i] = dr_reg[j][i];
                    dq_next[j+1][i] = dq_reg[j][i];
                end
            end
        end
    end

    // output stage
    logic              ov_reg;
    logic              ook_reg;
    unit_vec_t         ovec_reg, ovec_next;
    logic [SIDE_W-1:0] oside_reg;
    logic [UNIT_W-1:0] mag_u;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_u = UNIT_W'(dq_reg[DIV_STEPS][i]);
            if (dt_reg[DIV_STEPS].zero) begin
                ovec_next[i] = '0;
            end else begin
                ovec_next[i] = dt_reg[DIV_STEPS].neg[i] ? -mag_u : mag_u;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                sv_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= DIV_STEPS; j++) begin
                dv_reg[j] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            sv_reg[0] <= v4_reg;
            for (int j = 0; j < SQRT_STEPS; j++) begin
                sv_reg[j+1] <= sv_reg[j];
            end
            dv_reg[0] <= sv_reg[SQRT_STEPS];
            for (int j = 0; j < DIV_STEPS; j++) begin
                dv_reg[j+1] <= dv_reg[j];
            end
            ov_reg <= dv_reg[DIV_STEPS];
        end
        if (adv) begin
            t1_reg   <= '{neg: neg1_next, zero: 1'b0, side: in_side};
            mag1_reg <= mag1_next;
            max1_reg <= max1_next;
            t2_reg   <= '{neg: t1_reg.neg, zero: (max1_reg == '0), side: t1_reg.side};
            mag2_reg <= mag1_reg;
            pos2_reg <= pos2_next;
            t3_reg   <= t2_reg;
            nrm3_reg <= nrm3_next;
            t4_reg   <= t3_reg;
            nrm4_reg <= nrm3_reg;
            sq4_reg  <= sq4_next;
            st_reg[0]  <= t4_reg;
            snm_reg[0] <= nrm4_reg;
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                sqx_reg[j] <= sqx_next[j];
                sqr_reg[j] <= sqr_next[j];
            end
            for (int j = 0; j < SQRT_STEPS; j++) begin
                st_reg[j+1]  <= st_reg[j];
                snm_reg[j+1] <= snm_reg[j];
            end
            dt_reg[0] <= st_reg[SQRT_STEPS];
            dl_reg[0] <= len_next;
            for (int j = 0; j <= DIV_STEPS; j++) begin
                dr_reg[j] <= dr_next[j];
                dq_reg[j] <= dq_next[j];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                dt_reg[j+1] <= dt_reg[j];
                dl_reg[j+1] <= dl_reg[j];
            end
            ook_reg   <= !dt_reg[DIV_STEPS].zero;
            ovec_reg  <= ovec_next;
            oside_reg <= dt_reg[DIV_STEPS].side;
        end
    end

    assign out_stat = '{valid: ov_reg, ok: ook_reg};
    assign out_vec  = ovec_reg;
    assign out_side = oside_reg;

endmodule

### design/lavm_rows.sv
// ============================================================================
// lavm_rows
// Eye dot products, rounding and saturation, then a row buffer that sends
// the three matrix rows of one request on the result channel.
// ============================================================================
module lavm_rows (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lavm_pkg::nrm_stat_t         in_stat,
    input  lavm_pkg::unit_vec_t         in_right,
    input  lavm_pkg::unit_vec_t         in_up,
    input  lavm_pkg::unit_vec_t         in_dir,
    input  lavm_pkg::eye_vec_t          in_eye,
    input  logic                        m_ready,
    output logic                        adv,
    output logic                        m_valid,
    output logic [lavm_pkg::ROW_W-1:0]  m_row_index,
    output logic [lavm_pkg::EYE_W-1:0]  m_col_a,
    output logic [lavm_pkg::EYE_W-1:0]  m_col_b,
    output logic [lavm_pkg::EYE_W-1:0]  m_col_c,
    output logic [lavm_pkg::EYE_W-1:0]  m_col_d,
    output logic                        m_degenerate,
    output logic                        m_last_row
);
    import lavm_pkg::*;

    typedef unit_vec_t [2:0]              axes_t;
    typedef logic [2:0][2:0][PRD_W-1:0]   prd_mat_t;
    typedef logic [2:0][3:0][EYE_W-1:0]   row_mat_t;

    localparam logic signed [DOT_W-1:0] RND_C  = DOT_W'(1) << (FRAC_W - 1);
    localparam logic signed [DOT_W-1:0] SAT_HI = (DOT_W'(1) << (EYE_W - 1)) - DOT_W'(1);
    localparam logic signed [DOT_W-1:0] SAT_LO = ~SAT_HI;

    // stage A: products
    logic     va_reg, oka_reg;
    axes_t    axa_reg, axa_next;
    prd_mat_t prda_reg, prda_next;

    always_comb begin
        axa_next = {in_dir, in_up, in_right};
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                prda_next[r][i] = PRD_W'($signed(axa_next[r][i]))
                                * PRD_W'($signed(in_eye[i]));
            end
        end
    end

    // stage B: sums
    logic                   vb_reg, okb_reg;
    axes_t                  axb_reg;
    logic [2:0][DOT_W-1:0]  dotb_reg, dotb_next;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            dotb_next[r] = DOT_W'($signed(prda_reg[r][0]))
                         + DOT_W'($signed(prda_reg[r][1]))
                         + DOT_W'($signed(prda_reg[r][2]));
        end
    end

    // stage C: negate, round, saturate
    logic                     vc_reg, degc_reg;
    row_mat_t                 colc_reg, colc_next;
    logic signed [DOT_W-1:0]  t_c, q_c;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            t_c = RND_C - $signed(dotb_reg[r]);
            q_c = t_c >>> FRAC_W;
            for (int i = 0; i < 3; i++) begin
                colc_next[r][i] = EYE_W'($signed(axb_reg[r][i]));
            end
            if (q_c > SAT_HI) begin
                colc_next[r][3] = EYE_W'(SAT_HI);
            end else if (q_c < SAT_LO) begin
                colc_next[r][3] = EYE_W'(SAT_LO);
            end else begin
                colc_next[r][3] = EYE_W'(q_c);
            end
            if (!okb_reg) begin
                colc_next[r] = '0;
            end
        end
    end

    // row buffer
    logic     buf_v_reg, buf_deg_reg;
    row_mat_t buf_col_reg;
    row_t     cnt_reg, cnt_next;
    logic     take;

    assign take = !buf_v_reg || (m_ready && (cnt_reg == ROW_DIR));
    assign adv  = !vc_reg || take;

    always_comb begin
        case (cnt_reg)
            ROW_RIGHT: cnt_next = ROW_UP;
            ROW_UP:    cnt_next = ROW_DIR;
            default:   cnt_next = ROW_RIGHT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            buf_v_reg <= 1'b0;
            cnt_reg   <= ROW_RIGHT;
        end else begin
            if (adv) begin
                va_reg <= in_stat.valid;
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
            end
            if (take) begin
                buf_v_reg <= vc_reg;
                cnt_reg   <= ROW_RIGHT;
            end else if (m_ready) begin
                cnt_reg <= cnt_next;
            end
        end
        if (adv) begin
            oka_reg  <= in_stat.ok;
            axa_reg  <= axa_next;
            prda_reg <= prda_next;
            okb_reg  <= oka_reg;
            axb_reg  <= axa_reg;
            dotb_reg <= dotb_next;
            degc_reg <= !okb_reg;
            colc_reg <= colc_next;
        end
        if (take) begin
            buf_deg_reg <= degc_reg;
            buf_col_reg <= colc_reg;
        end
    end

    assign m_valid      = buf_v_reg;
    assign m_row_index  = cnt_reg;
    assign m_col_a      = buf_col_reg[cnt_reg][0];
    assign m_col_b      = buf_col_reg[cnt_reg][1];
    assign m_col_c      = buf_col_reg[cnt_reg][2];
    assign m_col_d      = buf_col_reg[cnt_reg][3];
    assign m_degenerate = buf_deg_reg;
    assign m_last_row   = (cnt_reg == ROW_DIR);

endmodule

### design/look_at_view_matrix_core.sv
// ============================================================================
// look_at_view_matrix_core
// Right-handed look-at view matrix, upper three rows, signed Q16.16.
// ============================================================================
// Input channel (s_valid/s_ready): one request carries eye and aim points.
// Result channel (m_valid/m_ready): three rows per request, row 0 right,
// row 1 up, row 2 direction; m_last_row marks row 2. Each row is the axis
// and the negated, rounded, saturated dot product with the eye.
// Eye equal to aim, or a view straight along the y axis, gives all-zero
// rows with m_degenerate set.
// The first row shows once the request has passed the whole path below; the
// other two rows follow when the receiver is ready.
// The three result rows of a request share one output port, which limits
// the request rate; the pipeline takes one request a cycle when not stalled.
// The path is three normalizers of 55 stages each (square root one bit
// per stage, divide one quotient bit per stage), a cross product, and dot
// product stages, all advancing together.
// A stalled receiver holds the row buffer; once a result waits behind it,
// the whole pipeline holds and s_ready drops, nothing is lost or repeated.
// Synchronous reset empties the pipeline and the row buffer.
// ============================================================================
module look_at_view_matrix_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [lavm_pkg::EYE_W-1:0]  s_eye_x,
    input  logic signed [lavm_pkg::EYE_W-1:0]  s_eye_y,
    input  logic signed [lavm_pkg::EYE_W-1:0]  s_eye_z,
    input  logic signed [lavm_pkg::EYE_W-1:0]  s_aim_x,
    input  logic signed [lavm_pkg::EYE_W-1:0]  s_aim_y,
    input  logic signed [lavm_pkg::EYE_W-1:0]  s_aim_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lavm_pkg::ROW_W-1:0]         m_row_index,
    output logic signed [lavm_pkg::EYE_W-1:0]  m_col_a,
    output logic signed [lavm_pkg::EYE_W-1:0]  m_col_b,
    output logic signed [lavm_pkg::EYE_W-1:0]  m_col_c,
    output logic signed [lavm_pkg::EYE_W-1:0]  m_col_d,
    output logic                               m_degenerate,
    output logic                               m_last_row
);
    import lavm_pkg::*;

    typedef struct packed {
        logic      ok;
        unit_vec_t dir;
        eye_vec_t  eye;
    } side2_t;

    typedef struct packed {
        logic      ok;
        unit_vec_t right;
        unit_vec_t dir;
        eye_vec_t  eye;
    } side3_t;

    logic adv;

    // input stage
    logic      v0_reg;
    eye_vec_t  eye0_reg;
    wide_vec_t dif0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
        if (adv) begin
            eye0_reg <= {s_eye_z, s_eye_y, s_eye_x};
            dif0_reg <= {VEC_W'(s_eye_z) - VEC_W'(s_aim_z),
                         VEC_W'(s_eye_y) - VEC_W'(s_aim_y),
                         VEC_W'(s_eye_x) - VEC_W'(s_aim_x)};
        end
    end

    // direction
    nrm_stat_t n1_stat;
    unit_vec_t dir1;
    eye_vec_t  eye1;

    lavm_norm #(.SIDE_W($bits(eye_vec_t))) u_norm_dir (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (v0_reg),
        .in_vec   (dif0_reg),
        .in_side  (eye0_reg),
        .out_stat (n1_stat),
        .out_vec  (dir1),
        .out_side (eye1)
    );

    // right = normalize(dir.z, 0, -dir.x)
    wide_vec_t rv1;
    side2_t    s2_in, s2_out;
    nrm_stat_t n2_stat;
    unit_vec_t right2;

    assign rv1   = {-VEC_W'($signed(dir1[0])), VEC_W'(0), VEC_W'($signed(dir1[2]))};
    assign s2_in = '{ok: n1_stat.ok, dir: dir1, eye: eye1};

    lavm_norm #(.SIDE_W($bits(side2_t))) u_norm_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (n1_stat.valid),
        .in_vec   (rv1),
        .in_side  (s2_in),
        .out_stat (n2_stat),
        .out_vec  (right2),
        .out_side (s2_out)
    );

    // cross product dir x right, products then differences
    logic                  vc1_reg, vc2_reg;
    side3_t                sc1_reg, sc2_reg;
    logic [5:0][VEC_W-1:0] prd1_reg, prd1_next;
    wide_vec_t             uv2_reg, uv2_next;

    always_comb begin
        prd1_next[0] = VEC_W'($signed(s2_out.dir[1])) * VEC_W'($signed(right2[2]));
        prd1_next[1] = VEC_W'($signed(s2_out.dir[2])) * VEC_W'($signed(right2[1]));
        prd1_next[2] = VEC_W'($signed(s2_out.dir[2])) * VEC_W'($signed(right2[0]));
        prd1_next[3] = VEC_W'($signed(s2_out.dir[0])) * VEC_W'($signed(right2[2]));
        prd1_next[4] = VEC_W'($signed(s2_out.dir[0])) * VEC_W'($signed(right2[1]));
        prd1_next[5] = VEC_W'($signed(s2_out.dir[1])) * VEC_W'($signed(right2[0]));
        for (int k = 0; k < 3; k++) begin
            uv2_next[k] = prd1_reg[2*k] - prd1_reg[2*k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc1_reg <= 1'b0;
            vc2_reg <= 1'b0;
        end else if (adv) begin
            vc1_reg <= n2_stat.valid;
            vc2_reg <= vc1_reg;
        end
        if (adv) begin
            sc1_reg  <= '{ok: s2_out.ok && n2_stat.ok, right: right2,
                          dir: s2_out.dir, eye: s2_out.eye};
            prd1_reg <= prd1_next;
            sc2_reg  <= sc1_reg;
            uv2_reg  <= uv2_next;
        end
    end

    // up
    nrm_stat_t n3_stat;
    unit_vec_t up3;
    side3_t    s3_out;
    nrm_stat_t rows_stat;

    lavm_norm #(.SIDE_W($bits(side3_t))) u_norm_up (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (vc2_reg),
        .in_vec   (uv2_reg),
        .in_side  (sc2_reg),
        .out_stat (n3_stat),
        .out_vec  (up3),
        .out_side (s3_out)
    );

    assign rows_stat = '{valid: n3_stat.valid, ok: n3_stat.ok && s3_out.ok};

    lavm_rows u_rows (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_stat      (rows_stat),
        .in_right     (s3_out.right),
        .in_up        (up3),
        .in_dir       (s3_out.dir),
        .in_eye       (s3_out.eye),
        .m_ready      (m_ready),
        .adv          (adv),
        .m_valid      (m_valid),
        .m_row_index  (m_row_index),
        .m_col_a      (m_col_a),
        .m_col_b      (m_col_b),
        .m_col_c      (m_col_c),
        .m_col_d      (m_col_d),
        .m_degenerate (m_degenerate),
        .m_last_row   (m_last_row)
    );

    assign s_ready = adv;

endmodule

### design/lavm_checker.sv
// ============================================================================
// lavm_checker
// Port-level checks on the result channel of the look-at view matrix core.
// ============================================================================
`include "look_at_view_matrix_core_defines.svh"

module lavm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [lavm_pkg::ROW_W-1:0]         m_row_index,
    input logic signed [lavm_pkg::EYE_W-1:0]  m_col_a,
    input logic signed [lavm_pkg::EYE_W-1:0]  m_col_b,
    input logic signed [lavm_pkg::EYE_W-1:0]  m_col_c,
    input logic signed [lavm_pkg::EYE_W-1:0]  m_col_d,
    input logic                               m_degenerate,
    input logic                               m_last_row
);
    import lavm_pkg::*;

    // rows of one request follow each other with the same flag
    `LAVM_ASSERT(a_row_seq, (m_valid && m_ready && m_row_index != ROW_DIR) |=> (m_valid && m_row_index == $past(m_row_index) + 2'd1 && m_degenerate == $past(m_degenerate)), "row sequence broken")

    `LAVM_ASSERT(a_last_row, m_valid |-> (m_last_row == (m_row_index == ROW_DIR)), "last_row mismatch")

    `LAVM_ASSERT(a_degen_zero, (m_valid && m_degenerate) |-> (m_col_a == 0 && m_col_b == 0 && m_col_c == 0 && m_col_d == 0), "degenerate row not zero")

    `LAVM_ASSERT(a_stall_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_row_index) && $stable(m_col_d)), "stalled row changed")

    `LAVM_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (.*);
